// ===== rtl/csd_pkg.sv =====
package csd_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int VALUE_BYTES = 8;

  localparam int VAL_W  = 8 * VALUE_BYTES;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PH_W   = $clog2(VALUE_BYTES);
  localparam int BSUM_W = $clog2(255 * VALUE_BYTES + 1);

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LEN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [BSUM_W-1:0] bsum;
    logic              done;
    logic              eoa;
  } asm_word_t;

endpackage

// ===== rtl/csd_asm.sv =====
module csd_asm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               eoa,
  output csd_pkg::asm_word_t word
);

  logic [csd_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic [csd_pkg::PH_W-1:0]   phase_r, phase_nxt;
  logic [csd_pkg::BSUM_W-1:0] sum_r, sum_nxt;
  logic                       last_byte;

  assign last_byte = (phase_r == csd_pkg::PH_W'(csd_pkg::VALUE_BYTES - 1));

  assign word.value = {val_r[csd_pkg::VAL_W-9:0], data_byte};
  assign word.bsum  = sum_r + csd_pkg::BSUM_W'(data_byte);
  assign word.done  = last_byte;
  assign word.eoa   = eoa;

  always_comb begin
    val_nxt   = val_r;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    if (take) begin
      if (last_byte || eoa) begin
        val_nxt   = '0;
        phase_nxt = '0;
        sum_nxt   = '0;
      end else begin
        val_nxt   = word.value;
        phase_nxt = phase_r + 1'b1;
        sum_nxt   = word.bsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r   <= '0;
      phase_r <= '0;
      sum_r   <= '0;
    end else begin
      val_r   <= val_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

// ===== rtl/csd_store.sv =====
module csd_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [csd_pkg::IDX_W-1:0] waddr,
  input  logic [csd_pkg::VAL_W-1:0] wdata,
  input  logic                      re,
  input  logic [csd_pkg::IDX_W-1:0] raddr,
  output logic [csd_pkg::VAL_W-1:0] rdata
);

  logic [csd_pkg::VAL_W-1:0] mem [csd_pkg::MAX_ENTRIES];
  logic [csd_pkg::VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/csd_seq.sv =====
module csd_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  output logic                       idle,
  input  csd_pkg::asm_word_t         word,
  output logic                       mem_we,
  output logic [csd_pkg::IDX_W-1:0]  mem_waddr,
  output logic [csd_pkg::VAL_W-1:0]  mem_wdata,
  output logic                       mem_re,
  output logic [csd_pkg::IDX_W-1:0]  mem_raddr,
  input  logic [csd_pkg::VAL_W-1:0]  mem_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                out_community_value,
  output logic                       out_entry_present,
  output logic [5:0]                 out_entry_count,
  output logic [15:0]                out_hash_key,
  output logic [1:0]                 out_status,
  output logic                       out_last_of_run
);

  localparam int CNT_W = csd_pkg::CNT_W;
  localparam int IDX_W = csd_pkg::IDX_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_OUT_RD   = 3'd5;
  localparam logic [2:0] S_OUT_LD   = 3'd6;
  localparam logic [2:0] S_ONE      = 3'd7;

  logic [2:0]                  st_r, st_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            pos_r, pos_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [csd_pkg::VAL_W-1:0]   v_r, v_nxt;
  logic [csd_pkg::BSUM_W-1:0]  vsum_r, vsum_nxt;
  logic                        end_r, end_nxt;
  logic [15:0]                 hash_r, hash_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [1:0]                  one_st_r, one_st_nxt;
  logic                        ov_r, ov_nxt;
  logic [63:0]                 oval_r, oval_nxt;
  logic                        opres_r, opres_nxt;
  logic [5:0]                  ocnt_r, ocnt_nxt;
  logic [15:0]                 ohash_r, ohash_nxt;
  logic [1:0]                  ost_r, ost_nxt;
  logic                        olast_r, olast_nxt;
  logic                        out_free, finish, ins_go, load, run_last;
  logic [CNT_W-1:0]            k_dec, idx_inc;

  assign out_free = !ov_r || out_ready;
  assign k_dec    = CNT_W'(k_r - 1'b1);
  assign idx_inc  = CNT_W'(idx_r + 1'b1);
  assign run_last = (idx_inc == cnt_r);
  assign idle     = (st_r == S_IDLE);

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    v_nxt      = v_r;
    vsum_nxt   = vsum_r;
    end_nxt    = end_r;
    hash_nxt   = hash_r;
    ovf_nxt    = ovf_r;
    one_st_nxt = one_st_r;
    ov_nxt     = ov_r && !out_ready;
    oval_nxt   = oval_r;
    opres_nxt  = opres_r;
    ocnt_nxt   = ocnt_r;
    ohash_nxt  = ohash_r;
    ost_nxt    = ost_r;
    olast_nxt  = olast_r;
    mem_we     = 1'b0;
    mem_waddr  = k_r[IDX_W-1:0];
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r[IDX_W-1:0];
    finish     = 1'b0;
    ins_go     = 1'b0;
    load       = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_take) begin
          if (word.done) begin
            v_nxt    = word.value;
            vsum_nxt = word.bsum;
            end_nxt  = word.eoa;
            idx_nxt  = '0;
            st_nxt   = S_SRCH_RD;
          end else if (word.eoa) begin
            one_st_nxt = csd_pkg::ST_LEN;
            st_nxt     = S_ONE;
          end
        end
      end
      S_SRCH_RD: begin
        if (idx_r == cnt_r) begin
          pos_nxt = idx_r;
          ins_go  = 1'b1;
        end else begin
          mem_re = 1'b1;
          st_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (mem_rdata < v_r) begin
          idx_nxt = idx_inc;
          st_nxt  = S_SRCH_RD;
        end else if (mem_rdata == v_r) begin
          finish = 1'b1;
        end else begin
          pos_nxt = idx_r;
          ins_go  = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (k_r == pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          mem_wdata = v_r;
          cnt_nxt   = CNT_W'(cnt_r + 1'b1);
          hash_nxt  = hash_r + 16'(vsum_r);
          finish    = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_dec[IDX_W-1:0];
          st_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        k_nxt  = k_dec;
        st_nxt = S_SHIFT_RD;
      end
      S_OUT_RD: begin
        mem_re = 1'b1;
        st_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (out_free) begin
          load      = 1'b1;
          oval_nxt  = mem_rdata;
          opres_nxt = 1'b1;
          ocnt_nxt  = 6'(cnt_r);
          ohash_nxt = hash_r;
          ost_nxt   = ovf_r ? csd_pkg::ST_OVF : csd_pkg::ST_OK;
          olast_nxt = run_last;
          idx_nxt   = idx_inc;
          if (run_last) begin
            cnt_nxt  = '0;
            hash_nxt = '0;
            ovf_nxt  = 1'b0;
            st_nxt   = S_IDLE;
          end else begin
            st_nxt = S_OUT_RD;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          load      = 1'b1;
          oval_nxt  = '0;
          opres_nxt = 1'b0;
          ocnt_nxt  = '0;
          ohash_nxt = '0;
          ost_nxt   = one_st_r;
          olast_nxt = 1'b1;
          cnt_nxt   = '0;
          hash_nxt  = '0;
          ovf_nxt   = 1'b0;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (ins_go) begin
      if (cnt_r == CNT_W'(csd_pkg::MAX_ENTRIES)) begin
        ovf_nxt = 1'b1;
        finish  = 1'b1;
      end else begin
        k_nxt  = cnt_r;
        st_nxt = S_SHIFT_RD;
      end
    end

    if (finish) begin
      if (!end_r) begin
        st_nxt = S_IDLE;
      end else if (cnt_nxt == '0) begin
        one_st_nxt = ovf_nxt ? csd_pkg::ST_OVF : csd_pkg::ST_OK;
        st_nxt     = S_ONE;
      end else begin
        idx_nxt = '0;
        st_nxt  = S_OUT_RD;
      end
    end

    if (load) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      hash_r   <= '0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
      idx_r    <= '0;
      end_r    <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      hash_r   <= hash_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
      idx_r    <= idx_nxt;
      end_r    <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    k_r      <= k_nxt;
    v_r      <= v_nxt;
    vsum_r   <= vsum_nxt;
    one_st_r <= one_st_nxt;
    oval_r   <= oval_nxt;
    opres_r  <= opres_nxt;
    ocnt_r   <= ocnt_nxt;
    ohash_r  <= ohash_nxt;
    ost_r    <= ost_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid           = ov_r;
  assign out_community_value = oval_r;
  assign out_entry_present   = opres_r;
  assign out_entry_count     = ocnt_r;
  assign out_hash_key        = ohash_r;
  assign out_status          = ost_r;
  assign out_last_of_run     = olast_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(csd_pkg::MAX_ENTRIES))
    else $error("store count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CNT_W'(csd_pkg::MAX_ENTRIES))
    else $error("overflow flagged with room left");

  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SHIFT_WR |-> k_r > pos_r)
    else $error("shift below insert position");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load && olast_nxt) |=> cnt_r == '0 && !ovf_r)
    else $error("store not cleared after run");
`endif

endmodule

// ===== rtl/ext_community_sort_dedup_top.sv =====
// Sorted, duplicate-free collector for BGP extended-community words.
// Input channel: one attribute byte per word (in_data_byte), wire order,
// with in_end_of_attribute on the final byte. Every 8 bytes form one
// big-endian 64-bit value that is inserted into an ascending store of
// MAX_ENTRIES entries; duplicates are dropped, excess values set overflow.
// Output channel: on the end byte the store is sent as a run of words in
// ascending order, last_of_run on the final one; an empty store or a
// length that is not a multiple of 8 gives a single word with
// entry_present low.
// A byte that does not complete a value or end the attribute leaves
// in_ready high. A completing byte runs a linear search up to insert
// position p and shifts the n-p of n stored entries above it (none for a
// duplicate or a full store), using a store with one read and one write
// port and 64-bit less-than and equality compares; in_ready stays low meanwhile.
// Each result word is emitted by a store read, then a load into the
// output register once that register is free.
// The output register lets the next attribute start while a word waits.
// A stalled receiver holds the run; the sequencer waits on it.
// Reset clears the sequencer, counts, hash and partial value; the store
// itself needs no clearing since only filled entries are read.
module ext_community_sort_dedup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_attribute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_community_value,
  output logic        out_entry_present,
  output logic [5:0]  out_entry_count,
  output logic [15:0] out_hash_key,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);

  csd_pkg::asm_word_t               word;
  logic                             take;
  logic                             idle;
  logic                             mem_we;
  logic                             mem_re;
  logic [csd_pkg::IDX_W-1:0]        mem_waddr;
  logic [csd_pkg::IDX_W-1:0]        mem_raddr;
  logic [csd_pkg::VAL_W-1:0]        mem_wdata;
  logic [csd_pkg::VAL_W-1:0]        mem_rdata;

  assign in_ready = idle;
  assign take     = in_valid && idle;

  csd_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .eoa       (in_end_of_attribute),
    .word      (word)
  );

  csd_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csd_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_take             (take),
    .idle                (idle),
    .word                (word),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_community_value (out_community_value),
    .out_entry_present   (out_entry_present),
    .out_entry_count     (out_entry_count),
    .out_hash_key        (out_hash_key),
    .out_status          (out_status),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
